[sv/qcf_pkg.sv]
// Shared types and constants of the quaternion complementary filter.
package qcf_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;

    typedef struct packed {
        logic signed [31:0] ref_dir_x;
        logic signed [31:0] ref_dir_y;
        logic signed [31:0] ref_dir_z;
        logic signed [31:0] ref_meas_x;
        logic signed [31:0] ref_meas_y;
        logic signed [31:0] ref_meas_z;
        logic signed [31:0] ref_weight;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic        [30:0] time_step;
        logic               last_ref;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] att_w;
        logic signed [31:0] att_x;
        logic signed [31:0] att_y;
        logic signed [31:0] att_z;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_wr;

endpackage

[sv/quaternion_complementary_filter_core.sv]
// Top level of the quaternion complementary filter: request queue and update engine.
// A reference pair runs 27 products through the one shared multiplier, each registered
// before it is accumulated, and then the engine takes the next request. A last pair adds
// 26 more products, normalizing shifts, a 32-step square root and four divisions, one
// quotient bit per cycle, plus any wait for the result to be taken.
// Synchronous active-low reset sets the attitude to identity and clears bias, sums and gains.
module quaternion_complementary_filter_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  qcf_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output qcf_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qcf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic              w_q_valid;
    logic              w_q_pop;
    qcf_pkg::t_in_item w_q_item;
    qcf_pkg::t_cfg_wr  w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    qcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_item   (w_q_item)
    );

    qcf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_item    (w_q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[sv/qcf_front.sv]
// Request queue that accepts reference pairs and hands them to the update engine.
module qcf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  qcf_pkg::t_in_item  i_in_item,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output qcf_pkg::t_in_item  o_q_item
);

    localparam int DEPTH = qcf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qcf_pkg::t_in_item r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_in_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[sv/qcf_back.sv]
// Update engine: shared multiplier sequencer, normalizing shifter, square root and divider.
module qcf_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qcf_pkg::t_cfg_wr   i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  qcf_pkg::t_in_item  i_q_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qcf_pkg::t_out_item o_out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DINIT = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [5:0] OP_PP    = 6'd0;
    localparam logic [5:0] OP_ROT   = 6'd9;
    localparam logic [5:0] OP_CROSS = 6'd18;
    localparam logic [5:0] OP_CORR  = 6'd24;
    localparam logic [5:0] OP_KDT   = 6'd27;
    localparam logic [5:0] OP_BIAS  = 6'd28;
    localparam logic [5:0] OP_KP    = 6'd31;
    localparam logic [5:0] OP_HDT   = 6'd34;
    localparam logic [5:0] OP_QUAT  = 6'd37;
    localparam logic [5:0] OP_SQ    = 6'd49;

    localparam int PP_XX = 0;
    localparam int PP_YY = 1;
    localparam int PP_ZZ = 2;
    localparam int PP_XY = 3;
    localparam int PP_XZ = 4;
    localparam int PP_YZ = 5;
    localparam int PP_WX = 6;
    localparam int PP_WY = 7;
    localparam int PP_WZ = 8;

    localparam logic signed [31:0] Q_ONE   = 32'sd1073741824;
    localparam logic        [63:0] BIT_TOP = 64'h4000_0000_0000_0000;

    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -66'sh8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    function automatic logic signed [31:0] clampq(input logic signed [34:0] v);
        if (v > 35'sd1073741824) begin
            return Q_ONE;
        end else if (v < -35'sd1073741824) begin
            return -Q_ONE;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
        return {{3{v[31]}}, v};
    endfunction

    logic [2:0]         r_state;
    logic               r_phase;
    logic [5:0]         r_op;
    qcf_pkg::t_in_item  r_item;
    logic [30:0]        r_gain_p;
    logic [30:0]        r_gain_i;
    logic signed [31:0] r_att  [4];
    logic signed [31:0] r_bias [3];
    logic signed [47:0] r_cs   [3];
    logic signed [31:0] r_pp   [9];
    logic signed [31:0] r_a    [3];
    logic signed [31:0] r_b    [3];
    logic signed [31:0] r_h    [3];
    logic signed [31:0] r_kdt;
    logic signed [63:0] r_nq   [4];
    logic signed [65:0] r_acc;
    logic signed [63:0] r_prod;
    logic [63:0]        r_mag  [4];
    logic [3:0]         r_neg;
    logic [63:0]        r_s;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [30:0]        r_rem;
    logic [30:0]        r_numlo;
    logic [30:0]        r_quo;
    logic [4:0]         r_cnt;
    logic [1:0]         r_di;
    logic               r_out_vld;
    qcf_pkg::t_out_item r_out;

    logic signed [31:0] d [3];
    logic signed [31:0] m [3];
    logic signed [31:0] g [3];
    logic signed [31:0] o [3];
    logic signed [31:0] rr [3][3];
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [65:0] pe;
    logic signed [31:0] ps;
    logic signed [31:0] qw, qx, qy, qz;
    logic [63:0]        n_sq_t;
    logic [31:0]        n_rem2;
    logic               n_qbit;
    logic [60:0]        n_num;
    logic               n_hi;
    logic               n_lo;
    logic [30:0]        n_q;
    logic               n_out_load;

    assign d[0] = r_item.ref_dir_x;
    assign d[1] = r_item.ref_dir_y;
    assign d[2] = r_item.ref_dir_z;
    assign m[0] = r_item.ref_meas_x;
    assign m[1] = r_item.ref_meas_y;
    assign m[2] = r_item.ref_meas_z;
    assign g[0] = r_item.gyro_x;
    assign g[1] = r_item.gyro_y;
    assign g[2] = r_item.gyro_z;
    assign qw   = r_att[0];
    assign qx   = r_att[1];
    assign qy   = r_att[2];
    assign qz   = r_att[3];
    assign pe   = {{2{r_prod[63]}}, r_prod};
    assign ps   = sat32(pe >>> FRAC_BITS);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o[i] = sat32({{18{r_cs[i][47]}}, r_cs[i]});
        end
        rr[0][0] = clampq(sx35(Q_ONE) - ((sx35(r_pp[PP_YY]) + sx35(r_pp[PP_ZZ])) <<< 1));
        rr[0][1] = clampq((sx35(r_pp[PP_XY]) - sx35(r_pp[PP_WZ])) <<< 1);
        rr[0][2] = clampq((sx35(r_pp[PP_XZ]) + sx35(r_pp[PP_WY])) <<< 1);
        rr[1][0] = clampq((sx35(r_pp[PP_XY]) + sx35(r_pp[PP_WZ])) <<< 1);
        rr[1][1] = clampq(sx35(Q_ONE) - ((sx35(r_pp[PP_XX]) + sx35(r_pp[PP_ZZ])) <<< 1));
        rr[1][2] = clampq((sx35(r_pp[PP_YZ]) - sx35(r_pp[PP_WX])) <<< 1);
        rr[2][0] = clampq((sx35(r_pp[PP_XZ]) - sx35(r_pp[PP_WY])) <<< 1);
        rr[2][1] = clampq((sx35(r_pp[PP_YZ]) + sx35(r_pp[PP_WX])) <<< 1);
        rr[2][2] = clampq(sx35(Q_ONE) - ((sx35(r_pp[PP_XX]) + sx35(r_pp[PP_YY])) <<< 1));
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_op)
            OP_PP + 6'd0:    begin op_a = qx; op_b = qx; end
            OP_PP + 6'd1:    begin op_a = qy; op_b = qy; end
            OP_PP + 6'd2:    begin op_a = qz; op_b = qz; end
            OP_PP + 6'd3:    begin op_a = qx; op_b = qy; end
            OP_PP + 6'd4:    begin op_a = qx; op_b = qz; end
            OP_PP + 6'd5:    begin op_a = qy; op_b = qz; end
            OP_PP + 6'd6:    begin op_a = qw; op_b = qx; end
            OP_PP + 6'd7:    begin op_a = qw; op_b = qy; end
            OP_PP + 6'd8:    begin op_a = qw; op_b = qz; end
            OP_ROT + 6'd0:   begin op_a = rr[0][0]; op_b = d[0]; end
            OP_ROT + 6'd1:   begin op_a = rr[1][0]; op_b = d[1]; end
            OP_ROT + 6'd2:   begin op_a = rr[2][0]; op_b = d[2]; end
            OP_ROT + 6'd3:   begin op_a = rr[0][1]; op_b = d[0]; end
            OP_ROT + 6'd4:   begin op_a = rr[1][1]; op_b = d[1]; end
            OP_ROT + 6'd5:   begin op_a = rr[2][1]; op_b = d[2]; end
            OP_ROT + 6'd6:   begin op_a = rr[0][2]; op_b = d[0]; end
            OP_ROT + 6'd7:   begin op_a = rr[1][2]; op_b = d[1]; end
            OP_ROT + 6'd8:   begin op_a = rr[2][2]; op_b = d[2]; end
            OP_CROSS + 6'd0: begin op_a = m[1]; op_b = r_a[2]; end
            OP_CROSS + 6'd1: begin op_a = m[2]; op_b = r_a[1]; end
            OP_CROSS + 6'd2: begin op_a = m[2]; op_b = r_a[0]; end
            OP_CROSS + 6'd3: begin op_a = m[0]; op_b = r_a[2]; end
            OP_CROSS + 6'd4: begin op_a = m[0]; op_b = r_a[1]; end
            OP_CROSS + 6'd5: begin op_a = m[1]; op_b = r_a[0]; end
            OP_CORR + 6'd0:  begin op_a = r_b[0]; op_b = r_item.ref_weight; end
            OP_CORR + 6'd1:  begin op_a = r_b[1]; op_b = r_item.ref_weight; end
            OP_CORR + 6'd2:  begin op_a = r_b[2]; op_b = r_item.ref_weight; end
            OP_KDT:          begin op_a = {1'b0, r_gain_i}; op_b = {1'b0, r_item.time_step}; end
            OP_BIAS + 6'd0:  begin op_a = o[0]; op_b = -r_kdt; end
            OP_BIAS + 6'd1:  begin op_a = o[1]; op_b = -r_kdt; end
            OP_BIAS + 6'd2:  begin op_a = o[2]; op_b = -r_kdt; end
            OP_KP + 6'd0:    begin op_a = o[0]; op_b = {1'b0, r_gain_p}; end
            OP_KP + 6'd1:    begin op_a = o[1]; op_b = {1'b0, r_gain_p}; end
            OP_KP + 6'd2:    begin op_a = o[2]; op_b = {1'b0, r_gain_p}; end
            OP_HDT + 6'd0:   begin op_a = r_h[0]; op_b = {1'b0, r_item.time_step}; end
            OP_HDT + 6'd1:   begin op_a = r_h[1]; op_b = {1'b0, r_item.time_step}; end
            OP_HDT + 6'd2:   begin op_a = r_h[2]; op_b = {1'b0, r_item.time_step}; end
            OP_QUAT + 6'd0:  begin op_a = qx; op_b = r_h[0]; end
            OP_QUAT + 6'd1:  begin op_a = qy; op_b = r_h[1]; end
            OP_QUAT + 6'd2:  begin op_a = qz; op_b = r_h[2]; end
            OP_QUAT + 6'd3:  begin op_a = qw; op_b = r_h[0]; end
            OP_QUAT + 6'd4:  begin op_a = qy; op_b = r_h[2]; end
            OP_QUAT + 6'd5:  begin op_a = qz; op_b = r_h[1]; end
            OP_QUAT + 6'd6:  begin op_a = qw; op_b = r_h[1]; end
            OP_QUAT + 6'd7:  begin op_a = qz; op_b = r_h[0]; end
            OP_QUAT + 6'd8:  begin op_a = qx; op_b = r_h[2]; end
            OP_QUAT + 6'd9:  begin op_a = qw; op_b = r_h[2]; end
            OP_QUAT + 6'd10: begin op_a = qx; op_b = r_h[1]; end
            OP_QUAT + 6'd11: begin op_a = qy; op_b = r_h[0]; end
            OP_SQ + 6'd0:    begin op_a = r_mag[0][31:0]; op_b = r_mag[0][31:0]; end
            OP_SQ + 6'd1:    begin op_a = r_mag[1][31:0]; op_b = r_mag[1][31:0]; end
            OP_SQ + 6'd2:    begin op_a = r_mag[2][31:0]; op_b = r_mag[2][31:0]; end
            OP_SQ + 6'd3:    begin op_a = r_mag[3][31:0]; op_b = r_mag[3][31:0]; end
            default:         begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb begin
        n_sq_t = r_res + r_bit;
        n_rem2 = {r_rem, r_numlo[30]};
        n_qbit = (n_rem2 >= {1'b0, r_res[30:0]});
        n_q    = {r_quo[29:0], n_qbit};
        n_num  = 61'({r_mag[r_di][29:0], 30'd0}) + 61'(r_res[30:1]);
        n_hi   = 1'b0;
        n_lo   = 1'b1;
        for (int i = 0; i < 4; i++) begin
            n_hi = n_hi | (|r_mag[i][63:30]);
            n_lo = n_lo & ~(|r_mag[i][63:29]);
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign n_out_load  = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= 1'b0;
            r_op      <= '0;
            r_out_vld <= 1'b0;
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_att[0]  <= Q_ONE;
            r_att[1]  <= '0;
            r_att[2]  <= '0;
            r_att[3]  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_bias[i] <= '0;
                r_cs[i]   <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    qcf_pkg::CFG_GAIN_P: r_gain_p <= i_cfg.data[30:0];
                    qcf_pkg::CFG_GAIN_I: r_gain_i <= i_cfg.data[30:0];
                    default: ;
                endcase
            end
            if (n_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_op    <= OP_PP;
                        r_phase <= 1'b0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (!r_phase) begin
                        r_prod  <= op_a * op_b;
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        case (r_op)
                            OP_PP + 6'd0, OP_PP + 6'd1, OP_PP + 6'd2,
                            OP_PP + 6'd3, OP_PP + 6'd4, OP_PP + 6'd5,
                            OP_PP + 6'd6, OP_PP + 6'd7, OP_PP + 6'd8: begin
                                r_pp[r_op[3:0]] <= r_prod[61:30];
                            end
                            OP_ROT + 6'd0, OP_ROT + 6'd3, OP_ROT + 6'd6,
                            OP_CROSS + 6'd0, OP_CROSS + 6'd2, OP_CROSS + 6'd4,
                            OP_QUAT + 6'd3, OP_QUAT + 6'd6, OP_QUAT + 6'd9: begin
                                r_acc <= pe;
                            end
                            OP_ROT + 6'd1, OP_ROT + 6'd4, OP_ROT + 6'd7,
                            OP_QUAT + 6'd4, OP_QUAT + 6'd7, OP_QUAT + 6'd10: begin
                                r_acc <= r_acc + pe;
                            end
                            OP_ROT + 6'd2:   r_a[0] <= sat32((r_acc + pe) >>> 30);
                            OP_ROT + 6'd5:   r_a[1] <= sat32((r_acc + pe) >>> 30);
                            OP_ROT + 6'd8:   r_a[2] <= sat32((r_acc + pe) >>> 30);
                            OP_CROSS + 6'd1: r_b[0] <= sat32((r_acc - pe) >>> FRAC_BITS);
                            OP_CROSS + 6'd3: r_b[1] <= sat32((r_acc - pe) >>> FRAC_BITS);
                            OP_CROSS + 6'd5: r_b[2] <= sat32((r_acc - pe) >>> FRAC_BITS);
                            OP_CORR + 6'd0: begin
                                r_cs[0] <= sat48({{18{r_cs[0][47]}}, r_cs[0]} + sx66(ps));
                            end
                            OP_CORR + 6'd1: begin
                                r_cs[1] <= sat48({{18{r_cs[1][47]}}, r_cs[1]} + sx66(ps));
                            end
                            OP_CORR + 6'd2: begin
                                r_cs[2] <= sat48({{18{r_cs[2][47]}}, r_cs[2]} + sx66(ps));
                            end
                            OP_KDT:         r_kdt <= ps;
                            OP_BIAS + 6'd0: r_bias[0] <= sat32(sx66(r_bias[0]) + sx66(ps));
                            OP_BIAS + 6'd1: r_bias[1] <= sat32(sx66(r_bias[1]) + sx66(ps));
                            OP_BIAS + 6'd2: r_bias[2] <= sat32(sx66(r_bias[2]) + sx66(ps));
                            OP_KP + 6'd0: begin
                                r_h[0] <= sat32(sx66(g[0]) - sx66(r_bias[0]) + sx66(ps));
                            end
                            OP_KP + 6'd1: begin
                                r_h[1] <= sat32(sx66(g[1]) - sx66(r_bias[1]) + sx66(ps));
                            end
                            OP_KP + 6'd2: begin
                                r_h[2] <= sat32(sx66(g[2]) - sx66(r_bias[2]) + sx66(ps));
                            end
                            OP_HDT + 6'd0:  r_h[0] <= sat32(pe >>> (FRAC_BITS + 1));
                            OP_HDT + 6'd1:  r_h[1] <= sat32(pe >>> (FRAC_BITS + 1));
                            OP_HDT + 6'd2:  r_h[2] <= sat32(pe >>> (FRAC_BITS + 1));
                            OP_QUAT + 6'd0: r_acc <= -pe;
                            OP_QUAT + 6'd1: r_acc <= r_acc - pe;
                            OP_QUAT + 6'd2: begin
                                r_nq[0] <= 64'(sx66(qw) + ((r_acc - pe) >>> FRAC_BITS));
                            end
                            OP_QUAT + 6'd5: begin
                                r_nq[1] <= 64'(sx66(qx) + ((r_acc - pe) >>> FRAC_BITS));
                            end
                            OP_QUAT + 6'd8: begin
                                r_nq[2] <= 64'(sx66(qy) + ((r_acc - pe) >>> FRAC_BITS));
                            end
                            OP_QUAT + 6'd11: begin
                                r_nq[3] <= 64'(sx66(qz) + ((r_acc - pe) >>> FRAC_BITS));
                            end
                            OP_SQ + 6'd0: r_s <= r_prod;
                            OP_SQ + 6'd1, OP_SQ + 6'd2, OP_SQ + 6'd3: begin
                                r_s <= r_s + r_prod;
                            end
                            default: ;
                        endcase

                        if ((r_op == OP_CORR + 6'd2) && !r_item.last_ref) begin
                            r_state <= S_IDLE;
                        end else if (r_op == OP_QUAT + 6'd11) begin
                            r_op    <= OP_SQ;
                            r_state <= S_NORM;
                        end else if (r_op == OP_SQ + 6'd3) begin
                            r_res   <= '0;
                            r_bit   <= BIT_TOP;
                            r_state <= S_SQRT;
                        end else begin
                            r_op <= r_op + 1'b1;
                        end
                    end
                end
                S_NORM: begin
                    for (int i = 0; i < 4; i++) begin
                        r_neg[i] <= r_nq[i][63];
                        r_mag[i] <= r_nq[i][63] ? 64'(-r_nq[i]) : 64'(r_nq[i]);
                    end
                    if ((r_nq[0] == '0) && (r_nq[1] == '0) && (r_nq[2] == '0) &&
                        (r_nq[3] == '0)) begin
                        r_att[0] <= Q_ONE;
                        r_att[1] <= '0;
                        r_att[2] <= '0;
                        r_att[3] <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (n_hi) begin
                        for (int i = 0; i < 4; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                    end else if (n_lo) begin
                        for (int i = 0; i < 4; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                    end else begin
                        r_phase <= 1'b0;
                        r_state <= S_MAC;
                    end
                end
                S_SQRT: begin
                    if (r_s >= n_sq_t) begin
                        r_s   <= r_s - n_sq_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_di    <= '0;
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_rem   <= {1'b0, n_num[60:31]};
                    r_numlo <= n_num[30:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= n_qbit ? 31'(n_rem2 - {1'b0, r_res[30:0]}) : n_rem2[30:0];
                    r_numlo <= r_numlo << 1;
                    r_quo   <= n_q;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == 5'd30) begin
                        r_att[r_di] <= r_neg[r_di] ? -{1'b0, n_q} : {1'b0, n_q};
                        if (r_di == 2'd3) begin
                            r_state <= S_DONE;
                        end else begin
                            r_di    <= r_di + 1'b1;
                            r_state <= S_DINIT;
                        end
                    end
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_out.att_w <= r_att[0];
                        r_out.att_x <= r_att[1];
                        r_out.att_y <= r_att[2];
                        r_out.att_z <= r_att[3];
                        for (int i = 0; i < 3; i++) begin
                            r_cs[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
